@@ design/bts_pkg.sv @@
// Shared types, constants and the tanh table for the biased tanh saturator.
package bts_pkg;

    // Sample format
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC        = SAMPLE_BITS - 4;
    localparam int DRIVE_BITS  = 17;

    // Tanh table geometry
    localparam int TANH_DEPTH  = 256;
    localparam int TANH_LOG2   = $clog2(TANH_DEPTH);
    localparam int TANH_FR     = FRAC + 3 - TANH_LOG2;
    localparam int TANH_ENT    = FRAC + 1;
    localparam int TANH_IN     = 35;
    localparam int TANH_OUT    = FRAC + 2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
    localparam logic [63:0] EXP_M1_Q30 = 64'd395007542;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MAX_PRE_GAIN  = 3'd0,
        CFG_MAX_BIAS      = 3'd1,
        CFG_MIN_LIN_GAIN  = 3'd2,
        CFG_DENORM_THR    = 3'd3,
        CFG_DRIVE_FLOOR   = 3'd4,
        CFG_DRIVE_CEILING = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] max_pre_gain;
        logic [14:0] max_bias;
        logic [8:0]  min_linear_gain;
        logic [7:0]  denormal_threshold;
        logic [16:0] drive_floor;
        logic [16:0] drive_ceiling;
    } t_cfg;

    // Classified item handed from front to back
    typedef struct packed {
        logic                          bypass;
        logic signed [SAMPLE_BITS-1:0] x;
        logic [DRIVE_BITS-1:0]         d;
    } t_item;

    // Per-item tag that rides along the back pipeline
    typedef struct packed {
        logic                          bypass;
        logic                          neg;
        logic signed [SAMPLE_BITS-1:0] x;
    } t_meta;

    typedef logic [TANH_ENT-1:0] t_tanh_rom [0:TANH_DEPTH];

    // Unsigned long division by shift and subtract, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b}) begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(8i/DEPTH) in Q.FRAC via (1-e)/(1+e), e = exp(-16i/DEPTH) in Q.30
    function automatic t_tanh_rom build_tanh_rom();
        t_tanh_rom   rom;
        logic [63:0] y;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        for (int i = 0; i <= TANH_DEPTH; i++) begin
            y    = (64'(i) << 34) >> TANH_LOG2;
            n    = y >> 30;
            f    = y & (ONE_Q30 - 64'd1);
            term = ONE_Q30;
            pos  = ONE_Q30;
            neg  = 64'd0;
            for (int k = 1; k <= 14; k++) begin
                term = udiv64((term * f) >> 30, 64'(k));
                if (k[0]) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            e = (pos > neg) ? pos - neg : 64'd0;
            for (int j = 0; j < 64; j++) begin
                if (64'(j) < n) begin
                    e = (e * EXP_M1_Q30) >> 30;
                end
            end
            num    = (ONE_Q30 - e) << FRAC;
            den    = ONE_Q30 + e;
            rom[i] = TANH_ENT'(udiv64(num + (den >> 1), den));
        end
        return rom;
    endfunction

    localparam t_tanh_rom TANH_ROM = build_tanh_rom();

endpackage

@@ design/biased_tanh_saturator.sv @@
// Items pass the queue, back pipeline, divider and output register; then o_valid strobes.
// Throughput: one item per cycle; the divider and both table lookups are pipelined.
// The front queue drains every cycle, so o_busy stays low and the receiver cannot stall.
// Reset (synchronous, active low) empties the pipeline and loads default config values.
// Top level: config registers, front end, item queue and back pipeline.
module biased_tanh_saturator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    output logic                                   o_busy,
    input  logic signed [bts_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic [bts_pkg::DRIVE_BITS-1:0]         i_drive,
    output logic                                   o_valid,
    output logic signed [bts_pkg::SAMPLE_BITS-1:0] o_sample_out,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [2:0]                             i_cfg_index,
    input  logic [16:0]                            i_cfg_data
);
    import bts_pkg::*;

    t_cfg  r_cfg;
    logic  w_push;
    logic  w_full;
    logic  w_empty;
    t_item w_fitem;
    t_item w_qitem;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = w_full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_pre_gain       <= 16'd1024;
            r_cfg.max_bias           <= 15'd3277;
            r_cfg.min_linear_gain    <= 9'd16;
            r_cfg.denormal_threshold <= 8'd1;
            r_cfg.drive_floor        <= 17'd0;
            r_cfg.drive_ceiling      <= 17'd65536;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_PRE_GAIN:  r_cfg.max_pre_gain       <= i_cfg_data[15:0];
                CFG_MAX_BIAS:      r_cfg.max_bias           <= i_cfg_data[14:0];
                CFG_MIN_LIN_GAIN:  r_cfg.min_linear_gain    <= i_cfg_data[8:0];
                CFG_DENORM_THR:    r_cfg.denormal_threshold <= i_cfg_data[7:0];
                CFG_DRIVE_FLOOR:   r_cfg.drive_floor        <= i_cfg_data;
                CFG_DRIVE_CEILING: r_cfg.drive_ceiling      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bts_front u_front (
        .i_start     (i_start),
        .i_full      (w_full),
        .i_sample_in (i_sample_in),
        .i_drive     (i_drive),
        .i_cfg       (r_cfg),
        .o_push      (w_push),
        .o_item      (w_fitem)
    );

    bts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .i_pop   (!w_empty),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_qitem)
    );

    bts_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (!w_empty),
        .i_item       (w_qitem),
        .i_cfg        (r_cfg),
        .o_valid      (o_valid),
        .o_sample_out (o_sample_out)
    );

endmodule

@@ design/bts_front.sv @@
// Front end: accepts an item, flushes tiny samples, clamps the drive and flags bypass.
module bts_front (
    input  logic                                 i_start,
    input  logic                                 i_full,
    input  logic signed [bts_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic [bts_pkg::DRIVE_BITS-1:0]       i_drive,
    input  bts_pkg::t_cfg                        i_cfg,
    output logic                                 o_push,
    output bts_pkg::t_item                       o_item
);
    import bts_pkg::*;

    logic [SAMPLE_BITS-1:0] w_mag;
    logic [DRIVE_BITS-1:0]  w_d_lo;
    logic [DRIVE_BITS-1:0]  w_d;

    assign o_push = i_start && !i_full;

    // Denormal flush on the incoming sample
    assign w_mag = i_sample_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_sample_in)
                                              : SAMPLE_BITS'(i_sample_in);

    // Drive clamp: raise to floor, then lower to ceiling
    assign w_d_lo = (i_drive < i_cfg.drive_floor) ? i_cfg.drive_floor : i_drive;
    assign w_d    = (w_d_lo > i_cfg.drive_ceiling) ? i_cfg.drive_ceiling : w_d_lo;

    always_comb begin
        o_item.x      = (w_mag < SAMPLE_BITS'(i_cfg.denormal_threshold)) ? '0 : i_sample_in;
        o_item.d      = w_d;
        o_item.bypass = (w_d <= i_cfg.drive_floor);
    end

endmodule

@@ design/bts_queue.sv @@
// Short item queue between the front end and the back pipeline.
module bts_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bts_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output bts_pkg::t_item o_item
);
    import bts_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_item             r_mem [0:QUEUE_DEPTH-1];
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_rp;
    logic [PW:0]       r_cnt;
    logic [PW:0]       n_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    // Occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

@@ design/bts_tanh.sv @@
// Three-stage table tanh with linear interpolation, Q.FRAC in and out.
module bts_tanh (
    input  logic                                   i_clk,
    input  logic signed [bts_pkg::TANH_IN-1:0]     i_arg,
    output logic signed [bts_pkg::TANH_OUT-1:0]    o_val
);
    import bts_pkg::*;

    logic [TANH_IN-1:0]    w_a;
    logic [TANH_LOG2:0]    w_idx;
    logic [TANH_ENT-1:0]   w_lo;
    logic [TANH_ENT-1:0]   w_hi;

    logic [TANH_ENT-1:0]   r1_lo;
    logic [TANH_ENT-1:0]   r1_diff;
    logic [TANH_FR-1:0]    r1_frac;
    logic                  r1_big;
    logic                  r1_neg;

    logic [TANH_ENT-1:0]             r2_lo;
    logic [TANH_ENT+TANH_FR-1:0]     r2_prod;
    logic                            r2_big;
    logic                            r2_neg;

    logic [TANH_ENT-1:0]   w_v;

    // Stage 1: magnitude, table index and both neighbors
    assign w_a   = i_arg[TANH_IN-1] ? TANH_IN'(-i_arg) : TANH_IN'(i_arg);
    assign w_idx = {1'b0, w_a[FRAC+2 -: TANH_LOG2]};
    assign w_lo  = TANH_ROM[w_idx];
    assign w_hi  = TANH_ROM[w_idx + (TANH_LOG2+1)'(1)];

    always_ff @(posedge i_clk) begin
        r1_lo   <= w_lo;
        r1_diff <= w_hi - w_lo;
        r1_frac <= w_a[TANH_FR-1:0];
        r1_big  <= (w_a >= (TANH_IN'(8) << FRAC));
        r1_neg  <= i_arg[TANH_IN-1];
    end

    // Stage 2: interpolation product
    always_ff @(posedge i_clk) begin
        r2_lo   <= r1_lo;
        r2_prod <= r1_diff * r1_frac;
        r2_big  <= r1_big;
        r2_neg  <= r1_neg;
    end

    // Stage 3: sum, saturate at one, restore sign
    assign w_v = r2_big ? TANH_ENT'(1) << FRAC
                        : r2_lo + r2_prod[TANH_ENT+TANH_FR-1:TANH_FR];

    always_ff @(posedge i_clk) begin
        o_val <= r2_neg ? -$signed({1'b0, w_v}) : $signed({1'b0, w_v});
    end

endmodule

@@ design/bts_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module bts_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [42:0]          i_num,
    input  logic [29:0]          i_den,
    input  bts_pkg::t_meta       i_meta,
    output logic                 o_valid,
    output logic                 o_ovf,
    output logic [bts_pkg::SAMPLE_BITS-1:0] o_quot,
    output bts_pkg::t_meta       o_meta
);
    import bts_pkg::*;

    localparam int QB = SAMPLE_BITS;
    localparam int SW = 30 + QB;

    logic [42:0]   r_rem  [0:QB];
    logic [29:0]   r_den  [0:QB];
    logic [QB-1:0] r_q    [0:QB];
    logic          r_ovf  [0:QB];
    t_meta         r_meta [0:QB];
    logic [QB:0]   r_vld;

    // Entry stage: quotient too large for the sample width
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_num;
        r_den[0]  <= i_den;
        r_q[0]    <= '0;
        r_ovf[0]  <= ({11'd0, i_num} >= {i_den, QB'(0)});
        r_meta[0] <= i_meta;
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [SW-1:0] w_sh;
        logic          w_ge;
        assign w_sh = {QB'(0), r_den[k]} << (QB - 1 - k);
        assign w_ge = {11'd0, r_rem[k]} >= w_sh;

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= w_ge ? r_rem[k] - w_sh[42:0] : r_rem[k];
            r_den[k+1]  <= r_den[k];
            r_q[k+1]    <= r_q[k] | (w_ge ? QB'(1) << (QB - 1 - k) : QB'(0));
            r_ovf[k+1]  <= r_ovf[k];
            r_meta[k+1] <= r_meta[k];
        end
    end

    // Valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QB-1:0], i_valid};
        end
    end

    assign o_valid = r_vld[QB];
    assign o_ovf   = r_ovf[QB];
    assign o_quot  = r_q[QB];
    assign o_meta  = r_meta[QB];

endmodule

@@ design/bts_back.sv @@
// Back pipeline: gain and bias, two tanh lookups, divisor, divide, saturate.
module bts_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  bts_pkg::t_item                         i_item,
    input  bts_pkg::t_cfg                          i_cfg,
    output logic                                   o_valid,
    output logic signed [bts_pkg::SAMPLE_BITS-1:0] o_sample_out
);
    import bts_pkg::*;

    localparam int TL = 3;

    // P1 products
    logic signed [16:0] w_gsub;
    logic signed [34:0] r1_m;
    logic [31:0]        r1_bm;
    t_meta              r1_meta;
    // P2 gain and bias
    logic signed [18:0] w_g;
    logic signed [17:0] r2_g;
    logic [20:0]        r2_b;
    logic signed [24:0] r2_xb;
    t_meta              r2_meta;
    // P3 tanh arguments
    logic signed [38:0] r3_pg;
    logic signed [42:0] r3_pv;
    logic signed [17:0] r3_g;
    t_meta              r3_meta;
    logic signed [TANH_IN-1:0]  w_tc;
    logic signed [TANH_IN-1:0]  w_tv;
    logic signed [TANH_OUT-1:0] w_c;
    logic signed [TANH_OUT-1:0] w_t;
    // Delay line alongside the tanh units
    logic signed [17:0] r_gd   [0:TL-1];
    t_meta              r_md   [0:TL-1];
    // P7..P9 divisor
    logic [20:0]        w_cm;
    logic signed [22:0] r7_s;
    logic [41:0]        r7_cc;
    logic signed [17:0] r7_g;
    t_meta              r7_meta;
    logic [20:0]        w_om;
    logic signed [22:0] r8_s;
    logic signed [38:0] r8_dm;
    t_meta              r8_meta;
    logic signed [30:0] w_dv;
    logic [29:0]        w_mlg;
    logic [29:0]        w_dmax;
    logic [22:0]        w_smag;
    logic [29:0]        r9_div;
    logic [42:0]        r9_num;
    t_meta              r9_meta;
    logic [TL+5:0]      r_vld;
    // Divider outputs and final stage
    logic                   w_dvalid;
    logic                   w_ovf;
    logic [SAMPLE_BITS-1:0] w_q;
    t_meta                  w_dmeta;
    logic [SAMPLE_BITS-1:0] w_res;
    logic [SAMPLE_BITS-1:0] w_rmag;

    // P1: drive times gain span, drive times bias
    assign w_gsub = $signed({1'b0, i_cfg.max_pre_gain}) - 17'sd256;

    always_ff @(posedge i_clk) begin
        r1_m           <= $signed({1'b0, i_item.d}) * w_gsub;
        r1_bm          <= i_cfg.max_bias * i_item.d;
        r1_meta.bypass <= i_item.bypass;
        r1_meta.neg    <= 1'b0;
        r1_meta.x      <= i_item.x;
    end

    // P2: g = 256 + floor(m / 2^16) in Q8, b = bm >> (31 - FRAC); g goes negative for small gain
    assign w_g = 19'sd256 + $signed(r1_m[34:16]);

    always_ff @(posedge i_clk) begin
        r2_g    <= w_g[17:0];
        r2_b    <= r1_bm[31:31-FRAC];
        r2_xb   <= $signed({r1_meta.x[SAMPLE_BITS-1], r1_meta.x})
                 + $signed({4'd0, r1_bm[31:31-FRAC]});
        r2_meta <= r1_meta;
    end

    // P3: scaled tanh arguments
    always_ff @(posedge i_clk) begin
        r3_pg   <= r2_g * $signed({1'b0, r2_b});
        r3_pv   <= r2_g * r2_xb;
        r3_g    <= r2_g;
        r3_meta <= r2_meta;
    end

    assign w_tc = TANH_IN'($signed(r3_pg[38:8]));
    assign w_tv = r3_pv[42:8];

    bts_tanh u_tanh_bias (
        .i_clk (i_clk),
        .i_arg (w_tc),
        .o_val (w_c)
    );

    bts_tanh u_tanh_sig (
        .i_clk (i_clk),
        .i_arg (w_tv),
        .o_val (w_t)
    );

    always_ff @(posedge i_clk) begin
        r_gd[0] <= r3_g;
        r_md[0] <= r3_meta;
        for (int i = 1; i < TL; i++) begin
            r_gd[i] <= r_gd[i-1];
            r_md[i] <= r_md[i-1];
        end
    end

    // P7: bias-removed output and squared bias tanh (square taken on the magnitude)
    assign w_cm = w_c[TANH_OUT-1] ? 21'(-w_c) : 21'(w_c);

    always_ff @(posedge i_clk) begin
        r7_s    <= 23'(w_t) - 23'(w_c);
        r7_cc   <= w_cm * w_cm;
        r7_g    <= r_gd[TL-1];
        r7_meta <= r_md[TL-1];
    end

    // P8: small-signal gain g * (1 - c^2)
    assign w_om = 21'(22'(1) << FRAC) - 21'(r7_cc[41:FRAC]);

    always_ff @(posedge i_clk) begin
        r8_dm   <= r7_g * $signed({1'b0, w_om});
        r8_s    <= r7_s;
        r8_meta <= r7_meta;
    end

    // P9: divisor limits and dividend magnitude
    assign w_dv   = r8_dm[38:8];
    assign w_mlg  = 30'(i_cfg.min_linear_gain) << (FRAC - 8);
    assign w_dmax = (w_dv < $signed({1'b0, w_mlg})) ? w_mlg : w_dv[29:0];
    assign w_smag = r8_s[22] ? 23'(-r8_s) : 23'(r8_s);

    always_ff @(posedge i_clk) begin
        r9_div         <= (w_dmax == '0) ? 30'd1 : w_dmax;
        r9_num         <= {w_smag, FRAC'(0)};
        r9_meta.bypass <= r8_meta.bypass;
        r9_meta.x      <= r8_meta.x;
        r9_meta.neg    <= r8_s[22];
    end

    // Valid line up to the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[$bits(r_vld)-2:0], i_valid};
        end
    end

    bts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[TL+5]),
        .i_num   (r9_num),
        .i_den   (r9_div),
        .i_meta  (r9_meta),
        .o_valid (w_dvalid),
        .o_ovf   (w_ovf),
        .o_quot  (w_q),
        .o_meta  (w_dmeta)
    );

    // Sign, saturation and second flush
    always_comb begin
        if (!w_dmeta.neg) begin
            w_res = (w_ovf || w_q[SAMPLE_BITS-1]) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}} : w_q;
        end else if (w_ovf || (w_q[SAMPLE_BITS-1] && (w_q[SAMPLE_BITS-2:0] != '0))) begin
            w_res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            w_res = -w_q;
        end
        w_rmag = w_res[SAMPLE_BITS-1] ? -w_res : w_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_dmeta.bypass) begin
            o_sample_out <= w_dmeta.x;
        end else if (w_rmag < SAMPLE_BITS'(i_cfg.denormal_threshold)) begin
            o_sample_out <= '0;
        end else begin
            o_sample_out <= $signed(w_res);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_dvalid;
        end
    end

endmodule

@@ bench/biased_tanh_saturator_tb.sv @@
// Self-checking testbench for the biased tanh saturator: directed and random items.
module biased_tanh_saturator_tb;
    import bts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 45;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_start = 1'b0;
    logic                          o_busy;
    logic signed [SAMPLE_BITS-1:0] i_sample_in = '0;
    logic [DRIVE_BITS-1:0]         i_drive = '0;
    logic                          o_valid;
    logic signed [SAMPLE_BITS-1:0] o_sample_out;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [2:0]                    i_cfg_index = '0;
    logic [16:0]                   i_cfg_data = '0;

    // Shadow copy of the configuration registers
    longint pre_gain_max, bias_max, lin_gain_min, flush_thr, drv_floor, drv_ceil;

    longint tanh_tab [0:TANH_DEPTH];
    logic signed [SAMPLE_BITS-1:0] clip_q [$];
    int errors = 0;
    bit idle_en = 1'b1;

    biased_tanh_saturator u_top (.*);

    always #1 i_clk = ~i_clk;

    // Table of tanh(8i/DEPTH) in Q.20, (1-e)/(1+e) with e = exp(-16i/DEPTH) in Q.30
    task automatic fill_tanh_tab();
        longint unsigned y, n, f, term, pos, neg, e, num, den;
        for (int i = 0; i <= TANH_DEPTH; i++) begin
            y    = (longint'(i) << 34) / TANH_DEPTH;
            n    = y >> 30;
            f    = y & ((64'd1 << 30) - 1);
            term = 64'd1 << 30;
            pos  = term;
            neg  = 0;
            for (int k = 1; k <= 14; k++) begin
                term = ((term * f) >> 30) / k;
                if (k % 2 == 1) begin
                    neg += term;
                end else begin
                    pos += term;
                end
            end
            e = (pos > neg) ? pos - neg : 0;
            for (longint unsigned k = 0; k < n; k++) begin
                e = (e * 64'd395007542) >> 30;
            end
            num = ((64'd1 << 30) - e) << FRAC;
            den = (64'd1 << 30) + e;
            tanh_tab[i] = longint'((num + den / 2) / den);
        end
    endtask

    function automatic longint tanh_q(input longint v);
        longint a, p, idx, r, res;
        a = (v < 0) ? -v : v;
        if (a >= (longint'(8) << FRAC)) begin
            res = longint'(1) << FRAC;
        end else begin
            p   = a * TANH_DEPTH;
            idx = p >> (FRAC + 3);
            r   = p & ((longint'(1) << (FRAC + 3)) - 1);
            if (idx > TANH_DEPTH - 1) idx = TANH_DEPTH - 1;
            res = tanh_tab[idx] + (((tanh_tab[idx+1] - tanh_tab[idx]) * r) >> (FRAC + 3));
        end
        return (v < 0) ? -res : res;
    endfunction

    function automatic longint flush_tiny(input longint s);
        longint m;
        m = (s < 0) ? -s : s;
        return (m < flush_thr) ? 0 : s;
    endfunction

    // Expected output sample for one item under the shadow configuration
    function automatic logic signed [SAMPLE_BITS-1:0] clip_predict(
        input logic signed [SAMPLE_BITS-1:0] s, input logic [DRIVE_BITS-1:0] dr);
        longint x, d, g, b, c, c2, dv, mlg, sat, res;
        x = flush_tiny(longint'(s));
        d = dr;
        if (d < drv_floor) d = drv_floor;
        if (d > drv_ceil) d = drv_ceil;
        if (d <= drv_floor) return x[SAMPLE_BITS-1:0];
        g   = 256 + ((d * (pre_gain_max - 256)) >>> 16);
        b   = (bias_max * d) >> (31 - FRAC);
        c   = tanh_q((g * b) >>> 8);
        c2  = (c * c) >>> FRAC;
        dv  = (g * ((longint'(1) << FRAC) - c2)) >>> 8;
        mlg = lin_gain_min * (longint'(1) << FRAC) / 256;
        if (dv < mlg) dv = mlg;
        if (dv < 1) dv = 1;
        sat = tanh_q((g * (x + b)) >>> 8) - c;
        res = sat * (longint'(1) << FRAC) / dv;
        if (res > (longint'(1) << (SAMPLE_BITS - 1)) - 1) res = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        if (res < -(longint'(1) << (SAMPLE_BITS - 1))) res = -(longint'(1) << (SAMPLE_BITS - 1));
        res = flush_tiny(res);
        return res[SAMPLE_BITS-1:0];
    endfunction

    // Predict on each accepted item, check each strobed result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) clip_q.push_back(clip_predict(i_sample_in, i_drive));
            if (o_valid) begin
                if (clip_q.size() == 0) begin
                    $error("sample_out: no item pending, actual %0d", o_sample_out);
                    errors++;
                end else begin
                    if (o_sample_out !== clip_q[0]) begin
                        $error("sample_out: expected %0d actual %0d", clip_q[0], o_sample_out);
                        errors++;
                    end
                    void'(clip_q.pop_front());
                end
            end
        end
    end

    // Stop sending and wait until every pending item has come out
    task automatic drain();
        i_start <= 1'b0;
        while (clip_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [16:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MAX_PRE_GAIN:  pre_gain_max = val[15:0];
            CFG_MAX_BIAS:      bias_max     = val[14:0];
            CFG_MIN_LIN_GAIN:  lin_gain_min = val[8:0];
            CFG_DENORM_THR:    flush_thr    = val[7:0];
            CFG_DRIVE_FLOOR:   drv_floor    = val;
            CFG_DRIVE_CEILING: drv_ceil     = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_all(input longint pg, bs, lg, th, fl, ce);
        drain();
        cfg_write(CFG_MAX_PRE_GAIN, pg);
        cfg_write(CFG_MAX_BIAS, bs);
        cfg_write(CFG_MIN_LIN_GAIN, lg);
        cfg_write(CFG_DENORM_THR, th);
        cfg_write(CFG_DRIVE_FLOOR, fl);
        cfg_write(CFG_DRIVE_CEILING, ce);
    endtask

    // One item: hold start until accepted, then, if idling is enabled, sometimes drop start for a random gap
    task automatic send_item(input logic signed [SAMPLE_BITS-1:0] s,
                             input logic [DRIVE_BITS-1:0] dr);
        i_start     <= 1'b1;
        i_sample_in <= s;
        i_drive     <= dr;
        do @(posedge i_clk); while (o_busy);
        if (idle_en && $urandom_range(0, 99) < 10) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return SAMPLE_BITS'($signed($urandom_range(0, 600)) - 300);
            1: return SAMPLE_BITS'($signed($urandom_range(0, 4_000_000)) - 2_000_000);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [DRIVE_BITS-1:0] rand_drive();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // Field extremes, bypass, flush threshold and saturation with defaults
    task automatic test_directed();
        send_item(24'sh7FFFFF, 17'd65536);
        send_item(-24'sh800000, 17'd65536);
        send_item(24'sd0, 17'd65536);
        send_item(24'sd1, 17'd0);
        send_item(-24'sd1, 17'd1);
        send_item(24'sh7FFFFF, 17'd0);
        send_item(-24'sh800000, 17'd0);
        send_item(24'sd1048576, 17'd32768);
        send_item(-24'sd1048576, 17'd32768);
        send_item(24'sd5, 17'h1FFFF);
        send_item(-24'sd3000000, 17'd65535);
    endtask

    // Register extremes: low gain, huge gain, crossed drive limits, big threshold
    task automatic test_config_extremes();
        set_all(256, 0, 1, 0, 0, 65536);
        send_item(24'sh7FFFFF, 17'd65536);
        send_item(-24'sd1, 17'd100);
        set_all(65535, 32767, 256, 255, 0, 65536);
        send_item(24'sd254, 17'd65536);
        send_item(-24'sd255, 17'd0);
        send_item(24'sd500000, 17'd65536);
        send_item(-24'sh800000, 17'd40000);
        set_all(0, 32767, 0, 0, 65536, 0);
        send_item(24'sd12345, 17'd65536);
        set_all(100, 1000, 1, 1, 30000, 20000);
        send_item(24'sd400000, 17'd65536);
        send_item(-24'sd400000, 17'd0);
        set_all(65535, 0, 256, 8, 65536, 65536);
        send_item(24'sd7, 17'd65536);
        send_item(24'sd9, 17'd0);
    endtask

    // Random items under random and default settings; first stretch has no gaps
    task automatic test_random();
        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 0) begin
                set_all(1024, 3277, 16, 1, 0, 65536);
            end else begin
                set_all($urandom_range(0, 65535), $urandom_range(0, 32767),
                        $urandom_range(0, 511), $urandom_range(0, 255),
                        $urandom_range(0, 20000), $urandom_range(20000, 131071));
            end
            idle_en = (ph != 0);
            for (int n = 0; n < 200; n++) send_item(rand_sample(), rand_drive());
            idle_en = 1'b1;
            // hold off once after phase 3 until the pipeline is empty
            if (ph == 3) begin
                drain();
            end
        end
    endtask

    initial begin
        fill_tanh_tab();
        pre_gain_max = 1024; bias_max = 3277; lin_gain_min = 16;
        flush_thr = 1; drv_floor = 0; drv_ceil = 65536;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_random();
        drain();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
design/bts_pkg.sv
design/bts_front.sv
design/bts_queue.sv
design/bts_tanh.sv
design/bts_div.sv
design/bts_back.sv
design/biased_tanh_saturator.sv
bench/biased_tanh_saturator_tb.sv
